@@ hw/rtl/sm3_hash_engine_top_macros.svh @@
// Assertion macros shared by the SM3 engine checker.
// Depends on nothing; included by the checker file only.
`ifndef SM3_HASH_ENGINE_TOP_MACROS_SVH
`define SM3_HASH_ENGINE_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SM3_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define SM3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hw/rtl/sm3_pkg.sv @@
// Types and constants of the SM3 hash engine.
// Depends on nothing; used by every module of the engine.
package sm3_pkg;

    // Payload of one input word.
    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } t_in_item;

    // Payload of one digest word.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_result;
    } t_out_item;

    // Classified word handed from the front end to the core: a block word,
    // and whether it closes a block and whether that block ends the message.
    typedef struct packed {
        logic [31:0] word;
        logic        block_end;
        logic        msg_end;
    } t_blk_word;

    localparam logic [31:0] T_LOW  = 32'h79cc4519;
    localparam logic [31:0] T_HIGH = 32'h7a879d8a;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [255:0] SM3_IV = {
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm_p1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

    function automatic logic [31:0] perm_p0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

endpackage

@@ hw/rtl/sm3_front.sv @@
// Front end: takes message words, counts length and emits padded block words.
// Depends on sm3_pkg.
module sm3_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  sm3_pkg::t_in_item     i_item,
    output logic                  o_stall,
    output logic                  o_valid,
    output sm3_pkg::t_blk_word    o_word,
    input  logic                  i_stall
);

    typedef enum logic [2:0] {
        S_TAKE = 3'b001,
        S_PAD  = 3'b010,
        S_LEN  = 3'b100
    } t_state;

    t_state      r_state, n_state;
    logic [3:0]  r_pos, n_pos;
    logic [63:0] r_bits, n_bits;
    logic        r_extra, n_extra;   // a full last word still owes the pad word
    logic        r_lenlo, n_lenlo;   // low length word is next

    logic [2:0]  cnt;
    logic [31:0] keep, padded;
    logic        emit;

    assign o_stall = (r_state != S_TAKE) || i_stall;
    assign emit    = o_valid && !i_stall;

    // Masked partial last word with the pad byte after its valid bytes.
    always_comb begin
        cnt = (i_item.byte_count > 3'd4) ? 3'd4 : i_item.byte_count;
        case (cnt)
            3'd0:    keep = 32'h00000000;
            3'd1:    keep = 32'hff000000;
            3'd2:    keep = 32'hffff0000;
            3'd3:    keep = 32'hffffff00;
            default: keep = 32'hffffffff;
        endcase
        padded = (i_item.data_word & keep) |
                 ({24'd0, sm3_pkg::PAD_BYTE} << (5'd24 - {cnt[1:0], 3'd0}));
    end

    // Word selection for the core.
    always_comb begin
        o_valid = 1'b0;
        o_word  = '0;
        case (r_state)
            S_TAKE: begin
                o_valid = i_valid;
                if (!i_item.last_word || cnt == 3'd4) begin
                    o_word.word = i_item.data_word;
                end else begin
                    o_word.word = padded;
                end
            end
            S_PAD: begin
                o_valid     = 1'b1;
                o_word.word = r_extra ? {sm3_pkg::PAD_BYTE, 24'd0} : 32'd0;
            end
            S_LEN: begin
                o_valid     = 1'b1;
                o_word.word = r_lenlo ? r_bits[31:0] : r_bits[63:32];
                o_word.msg_end = r_lenlo;
            end
            default: o_valid = 1'b0;
        endcase
        o_word.block_end = (r_pos == 4'd15);
    end

    // Sequencing of pad and length words.
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_bits  = r_bits;
        n_extra = r_extra;
        n_lenlo = r_lenlo;
        if (emit) begin
            n_pos = r_pos + 4'd1;
            case (r_state)
                S_TAKE: begin
                    if (!i_item.last_word) begin
                        n_bits = r_bits + 64'd32;
                    end else begin
                        n_bits  = r_bits + {58'd0, cnt, 3'd0};
                        n_extra = (cnt == 3'd4);
                        n_state = (cnt == 3'd4 || r_pos != 4'd13) ? S_PAD : S_LEN;
                        n_lenlo = 1'b0;
                    end
                end
                S_PAD: begin
                    n_extra = 1'b0;
                    if (r_pos == 4'd13) begin
                        n_state = S_LEN;
                    end
                end
                S_LEN: begin
                    n_lenlo = 1'b1;
                    if (r_lenlo) begin
                        n_state = S_TAKE;
                        n_bits  = '0;
                        n_pos   = '0;
                    end
                end
                default: n_state = S_TAKE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TAKE;
            r_pos   <= '0;
            r_bits  <= '0;
            r_extra <= 1'b0;
            r_lenlo <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_bits  <= n_bits;
            r_extra <= n_extra;
            r_lenlo <= n_lenlo;
        end
    end

endmodule

@@ hw/rtl/sm3_queue.sv @@
// Two-entry queue that decouples the front end from the compression core.
// Depends on sm3_pkg.
module sm3_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  sm3_pkg::t_blk_word    i_word,
    output logic                  o_stall,
    output logic                  o_valid,
    output sm3_pkg::t_blk_word    o_word,
    input  logic                  i_stall
);

    sm3_pkg::t_blk_word r_mem [2];
    logic               r_wp, r_rp;
    logic [1:0]         r_cnt;
    logic               push, pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_word;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ hw/rtl/sm3_core.sv @@
// Compression core: buffers a block, runs 64 rounds, one a cycle, and emits
// the digest. Depends on sm3_pkg.
module sm3_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  sm3_pkg::t_blk_word    i_word,
    output logic                  o_stall,
    output logic                  o_valid,
    output sm3_pkg::t_out_item    o_item,
    input  logic                  i_stall
);

    typedef enum logic [2:0] {
        S_LOAD  = 3'b001,
        S_ROUND = 3'b010,
        S_OUT   = 3'b100
    } t_state;

    t_state       r_state;
    logic [31:0]  r_w [16];         // sliding window of expanded words
    logic [31:0]  r_v [8];
    logic [31:0]  r_cv [8];
    logic [5:0]   r_rnd;
    logic [2:0]   r_idx;
    logic         r_end;

    logic [31:0]  wn, q, a12, s1, s2, ff, gg, u1, u2, tj;
    logic         lo;

    assign o_stall = (r_state != S_LOAD);
    assign o_valid = (r_state == S_OUT);
    assign o_item.digest_word = r_cv[r_idx];
    assign o_item.word_index  = r_idx;
    assign o_item.last_result = (r_idx == 3'd7);

    // One round of compression plus one step of message expansion.
    always_comb begin
        lo  = (r_rnd < 6'd16);
        q   = r_w[0] ^ r_w[7] ^ sm3_pkg::rotl(r_w[13], 5'd15);
        wn  = sm3_pkg::perm_p1(q) ^ sm3_pkg::rotl(r_w[3], 5'd7) ^ r_w[10];
        tj  = lo ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
        a12 = sm3_pkg::rotl(r_v[0], 5'd12);
        s1  = sm3_pkg::rotl(a12 + r_v[4] + sm3_pkg::rotl(tj, r_rnd[4:0]), 5'd7);
        s2  = s1 ^ a12;
        ff  = lo ? (r_v[0] ^ r_v[1] ^ r_v[2])
                 : ((r_v[0] & r_v[1]) | (r_v[0] & r_v[2]) | (r_v[1] & r_v[2]));
        gg  = lo ? (r_v[4] ^ r_v[5] ^ r_v[6]) : ((r_v[4] & r_v[5]) | (~r_v[4] & r_v[6]));
        u1  = ff + r_v[3] + s2 + (r_w[0] ^ r_w[4]);
        u2  = gg + r_v[7] + s1 + r_w[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_rnd   <= '0;
            r_idx   <= '0;
            r_end   <= 1'b0;
            for (int k = 0; k < 8; k++) begin
                r_cv[k] <= sm3_pkg::SM3_IV[255 - 32*k -: 32];
            end
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (i_valid) begin
                        for (int k = 0; k < 15; k++) begin
                            r_w[k] <= r_w[k+1];
                        end
                        r_w[15] <= i_word.word;
                        if (i_word.block_end) begin
                            r_end   <= i_word.msg_end;
                            r_rnd   <= '0;
                            r_state <= S_ROUND;
                            for (int k = 0; k < 8; k++) begin
                                r_v[k] <= r_cv[k];
                            end
                        end
                    end
                end
                S_ROUND: begin
                    for (int k = 0; k < 15; k++) begin
                        r_w[k] <= r_w[k+1];
                    end
                    r_w[15] <= wn;
                    r_v[0] <= u1;
                    r_v[1] <= r_v[0];
                    r_v[2] <= sm3_pkg::rotl(r_v[1], 5'd9);
                    r_v[3] <= r_v[2];
                    r_v[4] <= sm3_pkg::perm_p0(u2);
                    r_v[5] <= r_v[4];
                    r_v[6] <= sm3_pkg::rotl(r_v[5], 5'd19);
                    r_v[7] <= r_v[6];
                    r_rnd  <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) begin
                        for (int k = 0; k < 8; k++) begin
                            r_cv[k] <= r_cv[k] ^ ((k == 0) ? u1 :
                                (k == 4) ? sm3_pkg::perm_p0(u2) :
                                (k == 2) ? sm3_pkg::rotl(r_v[1], 5'd9) :
                                (k == 6) ? sm3_pkg::rotl(r_v[5], 5'd19) :
                                (k == 1) ? r_v[0] : (k == 3) ? r_v[2] :
                                (k == 5) ? r_v[4] : r_v[6]);
                        end
                        r_idx   <= '0;
                        r_state <= r_end ? S_OUT : S_LOAD;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_state <= S_LOAD;
                            for (int k = 0; k < 8; k++) begin
                                r_cv[k] <= sm3_pkg::SM3_IV[255 - 32*k -: 32];
                            end
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

endmodule

@@ hw/rtl/sm3_hash_engine_top.sv @@
// SM3 engine: the core loads a block's 16 words, one a cycle while the queue has
// words, then runs 64 rounds at one a cycle and takes no new words meanwhile.
// The first digest word follows the rounds of the last block, an extra one when
// the padding needs it; digest words leave one a cycle while i_stall is low.
// Reset (synchronous, active low) restores the IV and clears all counts.
// Depends on sm3_pkg, sm3_front, sm3_queue and sm3_core.
module sm3_hash_engine_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  sm3_pkg::t_in_item    i_data,
    output logic                 o_stall,
    output logic                 o_valid,
    output sm3_pkg::t_out_item   o_data,
    input  logic                 i_stall
);

    logic               f_valid, f_stall, q_valid, q_stall;
    sm3_pkg::t_blk_word f_word, q_word;

    sm3_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_item(i_data),
        .o_stall(o_stall), .o_valid(f_valid), .o_word(f_word), .i_stall(f_stall)
    );

    sm3_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid), .i_word(f_word),
        .o_stall(f_stall), .o_valid(q_valid), .o_word(q_word), .i_stall(q_stall)
    );

    sm3_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_word(q_word),
        .o_stall(q_stall), .o_valid(o_valid), .o_item(o_data), .i_stall(i_stall)
    );

endmodule

@@ hw/rtl/sm3_check.sv @@
// Port checker for the SM3 engine, bound to the top level.
// Depends on sm3_pkg and the assertion macros header.
`include "sm3_hash_engine_top_macros.svh"
module sm3_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input sm3_pkg::t_out_item o_data
);

    `SM3_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data), "stalled digest word changed")
    `SM3_ASSERT_NEXT(a_seq, i_clk, i_rst_n, o_valid && !i_stall && !o_data.last_result, o_valid && o_data.word_index == $past(o_data.word_index) + 3'd1, "digest words not consecutive")
    `SM3_ASSERT_IMPL(a_last, i_clk, i_rst_n, o_valid, o_data.last_result == (o_data.word_index == 3'd7), "last flag misplaced")

endmodule

bind sm3_hash_engine_top sm3_check u_check (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);

@@ tb/tb_sm3_hash_engine_top.sv @@
// Self-checking testbench for the SM3 hash engine: random and directed messages,
// with a digest predictor compared against every emitted digest word.
// Depends on sm3_pkg and sm3_hash_engine_top.
module tb_sm3_hash_engine_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    sm3_pkg::t_in_item  i_data = '0;
    logic               o_stall;
    logic               o_valid;
    sm3_pkg::t_out_item o_data;
    logic               i_stall = 1'b0;

    sm3_hash_engine_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_data(i_data),
        .o_stall(o_stall), .o_valid(o_valid), .o_data(o_data), .i_stall(i_stall)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: chaining words, pending block words and bit count.
    logic [31:0] hash_h [8];
    logic [31:0] blk_words [16];
    int unsigned blk_pos;
    logic [63:0] msg_len_bits;

    sm3_pkg::t_in_item  pending_words [$];
    sm3_pkg::t_out_item digest_queue [$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        idle_cycles = 0;
    bit        failed = 1'b0;
    bit        stim_done = 1'b0;

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        int k;
        k = n % 32;
        if (k == 0) return x;
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic void clear_hash();
        for (int j = 0; j < 8; j++) hash_h[j] = sm3_pkg::SM3_IV[255 - 32*j -: 32];
        blk_pos = 0;
        msg_len_bits = '0;
    endfunction

    function automatic void compress_words();
        logic [31:0] w [68];
        logic [31:0] v [8];
        logic [31:0] q, a12, s1, s2, ff, gg, u1, u2, tj;
        for (int j = 0; j < 16; j++) w[j] = blk_words[j];
        for (int j = 16; j < 68; j++) begin
            q = w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15);
            q = q ^ rol32(q, 15) ^ rol32(q, 23);
            w[j] = q ^ rol32(w[j-13], 7) ^ w[j-6];
        end
        for (int j = 0; j < 8; j++) v[j] = hash_h[j];
        for (int j = 0; j < 64; j++) begin
            tj = (j < 16) ? 32'h79cc4519 : 32'h7a879d8a;
            a12 = rol32(v[0], 12);
            s1 = rol32(a12 + v[4] + rol32(tj, j), 7);
            s2 = s1 ^ a12;
            if (j < 16) begin
                ff = v[0] ^ v[1] ^ v[2];
                gg = v[4] ^ v[5] ^ v[6];
            end else begin
                ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
                gg = (v[4] & v[5]) | (~v[4] & v[6]);
            end
            u1 = ff + v[3] + s2 + (w[j] ^ w[j+4]);
            u2 = gg + v[7] + s1 + w[j];
            v[3] = v[2]; v[2] = rol32(v[1], 9); v[1] = v[0]; v[0] = u1;
            v[7] = v[6]; v[6] = rol32(v[5], 19); v[5] = v[4];
            v[4] = u2 ^ rol32(u2, 9) ^ rol32(u2, 17);
        end
        for (int j = 0; j < 8; j++) hash_h[j] ^= v[j];
    endfunction

    function automatic void add_block_word(input logic [31:0] w);
        blk_words[blk_pos] = w;
        blk_pos = (blk_pos + 1) % 16;
        if (blk_pos == 0) compress_words();
    endfunction

    // Absorb one accepted word; on the last word, pad and queue the digest.
    function automatic void absorb_word(input sm3_pkg::t_in_item it);
        int unsigned nb;
        logic [31:0] keep;
        sm3_pkg::t_out_item r;
        if (!it.last_word) begin
            add_block_word(it.data_word);
            msg_len_bits += 64'd32;
            return;
        end
        nb = (it.byte_count > 4) ? 4 : it.byte_count;
        msg_len_bits += 64'(8 * nb);
        if (nb == 4) begin
            add_block_word(it.data_word);
            add_block_word({sm3_pkg::PAD_BYTE, 24'h0});
        end else begin
            keep = (nb == 0) ? 32'h0 : ~(32'hffffffff >> (8 * nb));
            add_block_word((it.data_word & keep) |
                           (32'(sm3_pkg::PAD_BYTE) << (24 - 8 * nb)));
        end
        if (blk_pos > 14) add_block_word('0);
        while (blk_pos < 14) add_block_word('0);
        add_block_word(msg_len_bits[63:32]);
        add_block_word(msg_len_bits[31:0]);
        for (int k = 0; k < 8; k++) begin
            r.digest_word = hash_h[k];
            r.word_index = 3'(k);
            r.last_result = (k == 7);
            digest_queue.push_back(r);
        end
        clear_hash();
    endfunction

    // Driver: presents queued words, holding each until it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) absorb_word(i_data);
            if (!(i_valid && o_stall)) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_data <= pending_words.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: checks each accepted digest word against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (digest_queue.size() == 0) begin
                $error("digest word with none expected: %h", o_data.digest_word);
                failed = 1'b1;
            end else begin
                sm3_pkg::t_out_item e;
                e = digest_queue.pop_front();
                if (o_data.digest_word !== e.digest_word) begin
                    $error("digest_word expected %h got %h", e.digest_word, o_data.digest_word);
                    failed = 1'b1;
                end
                if (o_data.word_index !== e.word_index) begin
                    $error("word_index expected %0d got %0d", e.word_index, o_data.word_index);
                    failed = 1'b1;
                end
                if (o_data.last_result !== e.last_result) begin
                    $error("last_result expected %0d got %0d", e.last_result,
                           o_data.last_result);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: cycles with no word accepted on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (i_rst_n && idle_cycles >= STALL_LIMIT && !stim_done) begin
            $display("sm3_hash_engine_top regression: fail");
            $finish;
        end
    end

    task automatic queue_word(input logic [31:0] d, input logic [2:0] nb, input logic lst);
        sm3_pkg::t_in_item it;
        it.data_word = d;
        it.byte_count = nb;
        it.last_word = lst;
        pending_words.push_back(it);
    endtask

    // One message of whole words followed by a last word of nb bytes.
    task automatic queue_message(input int n_full, input logic [2:0] nb);
        for (int j = 0; j < n_full; j++)
            queue_word($urandom, 3'($urandom_range(7)), 1'b0);
        queue_word($urandom, nb, 1'b1);
    endtask

    task automatic drain_all();
        while (pending_words.size() > 0 || i_valid || digest_queue.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    initial begin
        clear_hash();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty message, extreme data, every byte count, and a
        // length that forces an extra padding block.
        queue_word(32'h0, 3'd0, 1'b1);
        queue_word(32'hffffffff, 3'd4, 1'b1);
        queue_word(32'h61626300, 3'd3, 1'b1);
        queue_word(32'hffffffff, 3'd1, 1'b1);
        queue_word(32'hffffffff, 3'd2, 1'b1);
        queue_word(32'hffffffff, 3'd7, 1'b1);
        queue_word(32'hffffffff, 3'd5, 1'b0);
        queue_word(32'h0, 3'd6, 1'b1);
        queue_message(13, 3'd4);
        drain_all();

        // Random phases over the idling patterns.
        for (int ph = 0; ph < 4; ph++) begin
            int n_words;
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 32 : 73) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 32 : 73) : 0;
            n_words = 0;
            while (n_words < 105) begin
                int nf;
                nf = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(17);
                queue_message(nf, 3'($urandom_range(7)));
                n_words += nf + 1;
            end
            drain_all();
        end
        stim_done = 1'b1;

        if (!failed && digest_queue.size() == 0) begin
            $display("sm3_hash_engine_top regression: pass");
        end else begin
            $display("sm3_hash_engine_top regression: fail");
        end
        $finish;
    end

    // Overall guard against a hang while waiting for the tail.
    initial begin
        #50ms;
        $display("sm3_hash_engine_top regression: fail");
        $finish;
    end
endmodule
